FILE: rtl/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

    // Default word format: signed Q16.16.
    localparam int WORD_BITS_DEF     = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Command codes carried on the input tuser.
    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_CONJ  = 3'd4,
        CMD_NEG   = 3'd5,
        CMD_SQMAG = 3'd6,
        CMD_MAG   = 3'd7
    } cmd_t;

    // Control word that travels beside the data of each pipeline stage.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic dz;
        logic re_neg;
        logic im_neg;
        logic re_ovf;
        logic im_ovf;
    } ctl_t;

endpackage

FILE: rtl/cau_front.sv
`timescale 1ns / 1ps

module cau_front
    import cau_pkg::*;
#(
    parameter int WORD_BITS     = WORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  cmd_t                          in_cmd,
    input  logic signed [WORD_BITS-1:0]   in_a_re,
    input  logic signed [WORD_BITS-1:0]   in_a_im,
    input  logic signed [WORD_BITS-1:0]   in_b_re,
    input  logic signed [WORD_BITS-1:0]   in_b_im,
    output ctl_t                          out_ctl,
    output logic [2*WORD_BITS-1:0]        out_x_re,
    output logic [2*WORD_BITS-1:0]        out_x_im,
    output logic [WORD_BITS-1:0]          out_q_re,
    output logic [WORD_BITS-1:0]          out_q_im,
    output logic [2*WORD_BITS-1:0]        out_d
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int LW = W + 1;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = 2 * W + F;

    // Stage 0: captured item.
    ctl_t                s0_ctl_reg, s0_ctl_next;
    logic signed [W-1:0] s0_a_re_reg, s0_a_im_reg, s0_b_re_reg, s0_b_im_reg;

    always_comb begin
        s0_ctl_next       = '0;
        s0_ctl_next.valid = in_valid;
        s0_ctl_next.cmd   = in_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_ctl_reg <= '0;
        end else if (en) begin
            s0_ctl_reg <= s0_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_a_re_reg <= in_a_re;
            s0_a_im_reg <= in_a_im;
            s0_b_re_reg <= in_b_re;
            s0_b_im_reg <= in_b_im;
        end
    end

    // Stage 1: products and the linear commands.
    // For the magnitude commands the first two multipliers square a.
    ctl_t                 s1_ctl_reg;
    logic signed [PW-1:0] s1_m1_reg, s1_m2_reg, s1_ri_reg, s1_ir_reg;
    logic signed [PW-1:0] s1_bb_re_reg, s1_bb_im_reg;
    logic signed [LW-1:0] s1_lin_re_reg, s1_lin_im_reg;
    logic signed [PW-1:0] s1_m1_next, s1_m2_next, s1_ri_next, s1_ir_next;
    logic signed [PW-1:0] s1_bb_re_next, s1_bb_im_next;
    logic signed [LW-1:0] s1_lin_re_next, s1_lin_im_next;
    logic                 s1_square;
    logic signed [W-1:0]  s1_op_re, s1_op_im;

    always_comb begin
        s1_square      = (s0_ctl_reg.cmd inside {CMD_SQMAG, CMD_MAG});
        s1_op_re       = s1_square ? s0_a_re_reg : s0_b_re_reg;
        s1_op_im       = s1_square ? s0_a_im_reg : s0_b_im_reg;
        s1_m1_next     = PW'(s0_a_re_reg) * PW'(s1_op_re);
        s1_m2_next     = PW'(s0_a_im_reg) * PW'(s1_op_im);
        s1_ri_next     = PW'(s0_a_re_reg) * PW'(s0_b_im_reg);
        s1_ir_next     = PW'(s0_a_im_reg) * PW'(s0_b_re_reg);
        s1_bb_re_next  = PW'(s0_b_re_reg) * PW'(s0_b_re_reg);
        s1_bb_im_next  = PW'(s0_b_im_reg) * PW'(s0_b_im_reg);
        s1_lin_re_next = '0;
        s1_lin_im_next = '0;
        case (s0_ctl_reg.cmd)
            CMD_ADD: begin
                s1_lin_re_next = LW'(s0_a_re_reg) + LW'(s0_b_re_reg);
                s1_lin_im_next = LW'(s0_a_im_reg) + LW'(s0_b_im_reg);
            end
            CMD_SUB: begin
                s1_lin_re_next = LW'(s0_a_re_reg) - LW'(s0_b_re_reg);
                s1_lin_im_next = LW'(s0_a_im_reg) - LW'(s0_b_im_reg);
            end
            CMD_CONJ: begin
                s1_lin_re_next = LW'(s0_a_re_reg);
                s1_lin_im_next = -LW'(s0_a_im_reg);
            end
            CMD_NEG: begin
                s1_lin_re_next = -LW'(s0_a_re_reg);
                s1_lin_im_next = -LW'(s0_a_im_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else if (en) begin
            s1_ctl_reg <= s0_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_m1_reg     <= s1_m1_next;
            s1_m2_reg     <= s1_m2_next;
            s1_ri_reg     <= s1_ri_next;
            s1_ir_reg     <= s1_ir_next;
            s1_bb_re_reg  <= s1_bb_re_next;
            s1_bb_im_reg  <= s1_bb_im_next;
            s1_lin_re_reg <= s1_lin_re_next;
            s1_lin_im_reg <= s1_lin_im_next;
        end
    end

    // Stage 2: sums of products and the divisor |b|^2.
    ctl_t                 s2_ctl_reg;
    logic signed [SW-1:0] s2_sum_re_reg, s2_sum_im_reg, s2_sum_re_next, s2_sum_im_next;
    logic [PW-1:0]        s2_d_reg, s2_d_next;
    logic signed [LW-1:0] s2_lin_re_reg, s2_lin_im_reg;

    always_comb begin
        if (s1_ctl_reg.cmd == CMD_MUL) begin
            s2_sum_re_next = SW'(s1_m1_reg) - SW'(s1_m2_reg);
        end else begin
            s2_sum_re_next = SW'(s1_m1_reg) + SW'(s1_m2_reg);
        end
        if (s1_ctl_reg.cmd == CMD_DIV) begin
            s2_sum_im_next = SW'(s1_ir_reg) - SW'(s1_ri_reg);
        end else begin
            s2_sum_im_next = SW'(s1_ri_reg) + SW'(s1_ir_reg);
        end
        s2_d_next = $unsigned(s1_bb_re_reg) + $unsigned(s1_bb_im_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_ctl_reg <= '0;
        end else if (en) begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_sum_re_reg <= s2_sum_re_next;
            s2_sum_im_reg <= s2_sum_im_next;
            s2_d_reg      <= s2_d_next;
            s2_lin_re_reg <= s1_lin_re_reg;
            s2_lin_im_reg <= s1_lin_im_reg;
        end
    end

    // Stage 3: pick the value for the command, split into sign and magnitude.
    ctl_t                 s3_ctl_reg, s3_ctl_next;
    logic [PW-1:0]        s3_mag_re_reg, s3_mag_im_reg, s3_mag_re_next, s3_mag_im_next;
    logic [PW-1:0]        s3_d_reg;
    logic signed [SW-1:0] s3_v_re, s3_v_im;
    logic [SW-1:0]        s3_abs_re, s3_abs_im;

    always_comb begin
        if (s2_ctl_reg.cmd inside {CMD_ADD, CMD_SUB, CMD_CONJ, CMD_NEG}) begin
            s3_v_re = SW'(s2_lin_re_reg);
            s3_v_im = SW'(s2_lin_im_reg);
        end else begin
            s3_v_re = s2_sum_re_reg;
            s3_v_im = s2_sum_im_reg;
        end
        s3_abs_re          = s3_v_re[SW-1] ? -s3_v_re : s3_v_re;
        s3_abs_im          = s3_v_im[SW-1] ? -s3_v_im : s3_v_im;
        s3_mag_re_next     = s3_abs_re[PW-1:0];
        s3_mag_im_next     = s3_abs_im[PW-1:0];
        s3_ctl_next        = s2_ctl_reg;
        s3_ctl_next.re_neg = s3_v_re[SW-1];
        s3_ctl_next.im_neg = s3_v_im[SW-1];
        s3_ctl_next.dz     = (s2_ctl_reg.cmd == CMD_DIV) && (s2_d_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_ctl_reg <= '0;
        end else if (en) begin
            s3_ctl_reg <= s3_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_mag_re_reg <= s3_mag_re_next;
            s3_mag_im_reg <= s3_mag_im_next;
            s3_d_reg      <= s2_d_reg;
        end
    end

    // Stage 4: fraction shift, divider and square root setup.
    // The divider starts from the numerator bits above the quotient word; if
    // those already reach the divisor, the quotient does not fit a word.
    ctl_t            s4_ctl_reg, s4_ctl_next;
    logic [PW-1:0]   s4_x_re_reg, s4_x_im_reg, s4_x_re_next, s4_x_im_next;
    logic [W-1:0]    s4_q_re_reg, s4_q_im_reg, s4_q_re_next, s4_q_im_next;
    logic [PW-1:0]   s4_d_reg;
    logic [NW-1:0]   s4_n_re, s4_n_im;
    logic [W+F-1:0]  s4_top_re, s4_top_im;
    logic            s4_ovf_re, s4_ovf_im;

    always_comb begin
        s4_n_re      = NW'(s3_mag_re_reg) << F;
        s4_n_im      = NW'(s3_mag_im_reg) << F;
        s4_top_re    = s4_n_re[NW-1:W];
        s4_top_im    = s4_n_im[NW-1:W];
        s4_ovf_re    = (PW'(s4_top_re) >= s3_d_reg);
        s4_ovf_im    = (PW'(s4_top_im) >= s3_d_reg);
        s4_ctl_next  = s3_ctl_reg;
        s4_x_re_next = s3_mag_re_reg;
        s4_x_im_next = s3_mag_im_reg;
        s4_q_re_next = '0;
        s4_q_im_next = '0;
        case (s3_ctl_reg.cmd)
            CMD_MUL: begin
                s4_x_re_next = s3_mag_re_reg >> F;
                s4_x_im_next = s3_mag_im_reg >> F;
            end
            CMD_SQMAG: begin
                s4_x_re_next       = s3_mag_re_reg >> F;
                s4_x_im_next       = '0;
                s4_ctl_next.im_neg = 1'b0;
            end
            CMD_DIV: begin
                if (s3_ctl_reg.dz) begin
                    s4_x_re_next       = '0;
                    s4_x_im_next       = '0;
                    s4_ctl_next.re_neg = 1'b0;
                    s4_ctl_next.im_neg = 1'b0;
                end else begin
                    s4_ctl_next.re_ovf = s4_ovf_re;
                    s4_ctl_next.im_ovf = s4_ovf_im;
                    s4_x_re_next       = s4_ovf_re ? '0 : PW'(s4_top_re);
                    s4_x_im_next       = s4_ovf_im ? '0 : PW'(s4_top_im);
                    s4_q_re_next       = s4_n_re[W-1:0];
                    s4_q_im_next       = s4_n_im[W-1:0];
                end
            end
            CMD_MAG: begin
                // Remainder starts at zero, the radicand shifts out of x_im.
                s4_x_re_next       = '0;
                s4_x_im_next       = s3_mag_re_reg;
                s4_ctl_next.re_neg = 1'b0;
                s4_ctl_next.im_neg = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_ctl_reg <= '0;
        end else if (en) begin
            s4_ctl_reg <= s4_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_x_re_reg <= s4_x_re_next;
            s4_x_im_reg <= s4_x_im_next;
            s4_q_re_reg <= s4_q_re_next;
            s4_q_im_reg <= s4_q_im_next;
            s4_d_reg    <= s3_d_reg;
        end
    end

    assign out_ctl  = s4_ctl_reg;
    assign out_x_re = s4_x_re_reg;
    assign out_x_im = s4_x_im_reg;
    assign out_q_re = s4_q_re_reg;
    assign out_q_im = s4_q_im_reg;
    assign out_d    = s4_d_reg;

endmodule

FILE: rtl/cau_iter.sv
`timescale 1ns / 1ps

module cau_iter
    import cau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  ctl_t                   in_ctl,
    input  logic [2*WORD_BITS-1:0] in_x_re,
    input  logic [2*WORD_BITS-1:0] in_x_im,
    input  logic [WORD_BITS-1:0]   in_q_re,
    input  logic [WORD_BITS-1:0]   in_q_im,
    input  logic [2*WORD_BITS-1:0] in_d,
    output ctl_t                   out_ctl,
    output logic [2*WORD_BITS-1:0] out_x_re,
    output logic [2*WORD_BITS-1:0] out_x_im,
    output logic [WORD_BITS-1:0]   out_q_re,
    output logic [WORD_BITS-1:0]   out_q_im,
    output logic [2*WORD_BITS-1:0] out_d
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int RW = W + 4;

    ctl_t          ctl_reg;
    logic [PW-1:0] x_re_reg, x_im_reg, x_re_next, x_im_next, d_reg;
    logic [W-1:0]  q_re_reg, q_im_reg, q_re_next, q_im_next;

    // Divider bit: shift the next numerator bit into the remainder.
    logic [PW:0]   div_r_re, div_r_im, div_diff_re, div_diff_im;
    logic          div_ge_re, div_ge_im;

    // Square root bit: bring down two radicand bits and try root*4+1.
    logic [RW-1:0] sq_rem, sq_trial, sq_diff, sq_sel;
    logic          sq_ge;

    always_comb begin
        div_r_re    = {in_x_re, in_q_re[W-1]};
        div_r_im    = {in_x_im, in_q_im[W-1]};
        div_ge_re   = (div_r_re >= {1'b0, in_d});
        div_ge_im   = (div_r_im >= {1'b0, in_d});
        div_diff_re = div_r_re - {1'b0, in_d};
        div_diff_im = div_r_im - {1'b0, in_d};

        sq_rem      = {in_x_re[W+1:0], in_x_im[PW-1:PW-2]};
        sq_trial    = {2'b00, in_q_re, 2'b01};
        sq_ge       = (sq_rem >= sq_trial);
        sq_diff     = sq_rem - sq_trial;
        sq_sel      = sq_ge ? sq_diff : sq_rem;

        x_re_next   = in_x_re;
        x_im_next   = in_x_im;
        q_re_next   = in_q_re;
        q_im_next   = in_q_im;
        case (in_ctl.cmd)
            CMD_DIV: begin
                x_re_next = div_ge_re ? div_diff_re[PW-1:0] : div_r_re[PW-1:0];
                x_im_next = div_ge_im ? div_diff_im[PW-1:0] : div_r_im[PW-1:0];
                q_re_next = {in_q_re[W-2:0], div_ge_re};
                q_im_next = {in_q_im[W-2:0], div_ge_im};
            end
            CMD_MAG: begin
                x_re_next = PW'(sq_sel[W+1:0]);
                x_im_next = in_x_im << 2;
                q_re_next = {in_q_re[W-2:0], sq_ge};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_re_reg <= x_re_next;
            x_im_reg <= x_im_next;
            q_re_reg <= q_re_next;
            q_im_reg <= q_im_next;
            d_reg    <= in_d;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_x_re = x_re_reg;
    assign out_x_im = x_im_reg;
    assign out_q_re = q_re_reg;
    assign out_q_im = q_im_reg;
    assign out_d    = d_reg;

endmodule

FILE: rtl/cau_output.sv
`timescale 1ns / 1ps

module cau_output
    import cau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  ctl_t                   in_ctl,
    input  logic [2*WORD_BITS-1:0] in_x_re,
    input  logic [2*WORD_BITS-1:0] in_x_im,
    input  logic [WORD_BITS-1:0]   in_q_re,
    input  logic [WORD_BITS-1:0]   in_q_im,
    output logic                   out_valid,
    output logic [WORD_BITS-1:0]   out_re,
    output logic [WORD_BITS-1:0]   out_im,
    output logic                   out_sat,
    output logic                   out_dz
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;

    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (W - 1);
    localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);
    localparam logic [W-1:0]  WORD_MIN = LIM_NEG[W-1:0];
    localparam logic [W-1:0]  WORD_MAX = LIM_POS[W-1:0];

    logic          valid_reg, sat_reg, dz_reg, sat_next;
    logic [W-1:0]  re_reg, im_reg, re_next, im_next;
    logic [PW-1:0] mag_re, mag_im;
    logic          neg_re, neg_im, ovf_re, ovf_im, clip_re, clip_im;

    // Final magnitude per command, then clip to the word range.
    always_comb begin
        mag_re = in_x_re;
        mag_im = in_x_im;
        neg_re = in_ctl.re_neg;
        neg_im = in_ctl.im_neg;
        ovf_re = 1'b0;
        ovf_im = 1'b0;
        case (in_ctl.cmd)
            CMD_DIV: begin
                if (!in_ctl.dz) begin
                    mag_re = PW'(in_q_re);
                    mag_im = PW'(in_q_im);
                end
                ovf_re = in_ctl.re_ovf;
                ovf_im = in_ctl.im_ovf;
            end
            CMD_MAG: begin
                mag_re = PW'(in_q_re);
                mag_im = '0;
            end
            default: begin
            end
        endcase

        clip_re = ovf_re || (mag_re > (neg_re ? LIM_NEG : LIM_POS));
        clip_im = ovf_im || (mag_im > (neg_im ? LIM_NEG : LIM_POS));

        if (clip_re) begin
            re_next = neg_re ? WORD_MIN : WORD_MAX;
        end else begin
            re_next = neg_re ? -mag_re[W-1:0] : mag_re[W-1:0];
        end
        if (clip_im) begin
            im_next = neg_im ? WORD_MIN : WORD_MAX;
        end else begin
            im_next = neg_im ? -mag_im[W-1:0] : mag_im[W-1:0];
        end
        sat_next = clip_re || clip_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            sat_reg <= sat_next;
            dz_reg  <= in_ctl.dz;
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;
    assign out_sat   = sat_reg;
    assign out_dz    = dz_reg;

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed fixed-point operands.
// An item passes the front stages, the iteration stages and the output register.
// Throughput: one item per cycle unless the output stalls; the divider and square
// root take one quotient or root bit per pipeline stage, WORD_BITS stages in all.
// A stall at the output holds every stage at once.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int  WORD_BITS     = WORD_BITS_DEF,
    parameter int  FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IN_DATA_W     = ((4 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W    = ((2 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // a_re, a_im, b_re, b_im from the lowest bit up
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // res_re, res_im from the lowest bit up
    output logic [OUT_DATA_W-1:0] m_tdata,
    // saturated, divide_by_zero from the lowest bit up
    output logic [1:0]            m_tuser
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;

    logic         en;
    logic [W-1:0] res_re, res_im;
    logic         res_sat, res_dz;

    ctl_t          chain_ctl  [0:W];
    logic [PW-1:0] chain_x_re [0:W];
    logic [PW-1:0] chain_x_im [0:W];
    logic [W-1:0]  chain_q_re [0:W];
    logic [W-1:0]  chain_q_im [0:W];
    logic [PW-1:0] chain_d    [0:W];

    // The whole pipeline advances unless a finished item waits at the output.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_front #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_cmd   (cmd_t'(s_tuser)),
        .in_a_re  (s_tdata[W-1:0]),
        .in_a_im  (s_tdata[2*W-1:W]),
        .in_b_re  (s_tdata[3*W-1:2*W]),
        .in_b_im  (s_tdata[4*W-1:3*W]),
        .out_ctl  (chain_ctl[0]),
        .out_x_re (chain_x_re[0]),
        .out_x_im (chain_x_im[0]),
        .out_q_re (chain_q_re[0]),
        .out_q_im (chain_q_im[0]),
        .out_d    (chain_d[0])
    );

    // One quotient bit and one root bit per stage.
    for (genvar i = 0; i < W; i++) begin : g_iter
        cau_iter #(
            .WORD_BITS (WORD_BITS)
        ) u_iter (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_ctl   (chain_ctl[i]),
            .in_x_re  (chain_x_re[i]),
            .in_x_im  (chain_x_im[i]),
            .in_q_re  (chain_q_re[i]),
            .in_q_im  (chain_q_im[i]),
            .in_d     (chain_d[i]),
            .out_ctl  (chain_ctl[i+1]),
            .out_x_re (chain_x_re[i+1]),
            .out_x_im (chain_x_im[i+1]),
            .out_q_re (chain_q_re[i+1]),
            .out_q_im (chain_q_im[i+1]),
            .out_d    (chain_d[i+1])
        );
    end

    cau_output #(
        .WORD_BITS (WORD_BITS)
    ) u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_ctl    (chain_ctl[W]),
        .in_x_re   (chain_x_re[W]),
        .in_x_im   (chain_x_im[W]),
        .in_q_re   (chain_q_re[W]),
        .in_q_im   (chain_q_im[W]),
        .out_valid (m_tvalid),
        .out_re    (res_re),
        .out_im    (res_im),
        .out_sat   (res_sat),
        .out_dz    (res_dz)
    );

    assign m_tdata = OUT_DATA_W'({res_im, res_re});
    assign m_tuser = {res_dz, res_sat};

    // A divide by zero gives a zero result and is not counted as clipped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> ((m_tdata[2*W-1:0] == '0) && !m_tuser[0]))
    else $error("divide by zero item with nonzero result or saturation");

    // A waiting result blocks new items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while the output is stalled");

    // A magnitude leaving the last stage is nonnegative with zero imaginary part.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && chain_ctl[W].valid && (chain_ctl[W].cmd == CMD_MAG))
        |=> (m_tvalid && !m_tdata[W-1] && (m_tdata[2*W-1:W] == '0)))
    else $error("magnitude result negative or with imaginary part");

endmodule
